### hw/rtl/command_frame_parser_with_timeout_defines.svh
// Assertion helpers shared by the frame parser RTL.
`ifndef COMMAND_FRAME_PARSER_WITH_TIMEOUT_DEFINES_SVH
`define COMMAND_FRAME_PARSER_WITH_TIMEOUT_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while in reset.
`define CFPT_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("frame parser assertion failed");

// Next-cycle implication, sampled on clk, off while in reset.
`define CFPT_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("frame parser assertion failed");

`endif

### hw/rtl/cfpt_pkg.sv
package cfpt_pkg;

	localparam int FRAME_MAX_BYTES = 9;

	localparam logic [7:0] HDR_FIRST = 8'hA5;
	localparam logic [7:0] HDR_VEL   = 8'h5A;
	localparam logic [7:0] HDR_ACT   = 8'h5B;

	localparam logic [3:0] LEN_VEL = 4'(FRAME_MAX_BYTES);
	localparam logic [3:0] LEN_ACT = 4'd3;

	localparam logic [16:0] ELAPSED_MAX = 17'h1FFFF;

	localparam logic [7:0]  ACTION_LIMIT_RST  = 8'd255;
	localparam logic [15:0] TIMEOUT_TICKS_RST = 16'd500;

	// register index, taken from paddr[2]
	localparam logic REG_ACTION_LIMIT  = 1'b0;
	localparam logic REG_TIMEOUT_TICKS = 1'b1;

	localparam int EVQ_DEPTH  = 4;
	localparam int RESQ_DEPTH = 2;

	typedef struct packed {
		logic       kind;
		logic [7:0] byte_value;
	} in_word_t;

	typedef struct packed {
		logic              command_valid;
		logic signed [15:0] vel_x;
		logic signed [15:0] vel_y;
		logic signed [15:0] rotation;
		logic              action_valid;
		logic [7:0]        action_code;
		logic              link_up;
		logic              stop_pulse;
	} out_word_t;

	typedef enum logic [1:0] {
		EV_NONE,
		EV_TICK,
		EV_VEL,
		EV_ACT
	} ev_kind_t;

	typedef struct packed {
		ev_kind_t          kind;
		logic signed [15:0] vel_x;
		logic signed [15:0] vel_y;
		logic signed [15:0] rotation;
		logic [7:0]        action_code;
	} ev_t;

endpackage

### hw/rtl/cfpt_front.sv
module cfpt_front import cfpt_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       accept,
	input  in_word_t   item,
	input  logic [7:0] action_limit,
	output ev_t        ev
);

	typedef enum logic [1:0] {
		PH_WAIT0,
		PH_WAIT1,
		PH_BODY
	} phase_t;

	phase_t     phase_q, phase_d;
	logic       is_vel_q, is_vel_d;
	logic [3:0] pos_q, pos_d;
	logic [7:0] xor_q, xor_d;
	logic [7:0] frame_q [2:7];
	logic [3:0] pos_inc;
	logic [3:0] len;
	logic [7:0] b;

	assign b       = item.byte_value;
	assign pos_inc = pos_q + 4'd1;
	assign len     = is_vel_q ? LEN_VEL : LEN_ACT;

	always_comb begin
		ev.kind        = EV_NONE;
		ev.vel_x       = '0;
		ev.vel_y       = '0;
		ev.rotation    = '0;
		ev.action_code = '0;
		phase_d        = phase_q;
		is_vel_d       = is_vel_q;
		pos_d          = pos_q;
		xor_d          = xor_q;
		if (item.kind) begin
			ev.kind = EV_TICK;
		end else begin
			case (phase_q)
				PH_WAIT0: begin
					if (b == HDR_FIRST) phase_d = PH_WAIT1;
				end
				PH_WAIT1: begin
					if (b == HDR_VEL || b == HDR_ACT) begin
						is_vel_d = (b == HDR_VEL);
						pos_d    = 4'd2;
						xor_d    = '0;
						phase_d  = PH_BODY;
					end else if (b != HDR_FIRST) begin
						phase_d = PH_WAIT0;
						pos_d   = '0;
					end
				end
				PH_BODY: begin
					if (pos_q inside {[4'd2:4'd7]}) xor_d = xor_q ^ b;
					pos_d = pos_inc;
					if (pos_inc >= len) begin
						phase_d = PH_WAIT0;
						pos_d   = '0;
						if (is_vel_q) begin
							// checksum byte is the current one
							if (b == xor_q) begin
								ev.kind     = EV_VEL;
								ev.vel_x    = {frame_q[3], frame_q[2]};
								ev.vel_y    = {frame_q[5], frame_q[4]};
								ev.rotation = {frame_q[7], frame_q[6]};
							end
						end else if (b <= action_limit) begin
							ev.kind        = EV_ACT;
							ev.action_code = b;
						end
					end
				end
				default: begin
					phase_d = PH_WAIT0;
					pos_d   = '0;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_WAIT0;
			is_vel_q <= 1'b0;
			pos_q    <= '0;
			xor_q    <= '0;
		end else if (accept) begin
			phase_q  <= phase_d;
			is_vel_q <= is_vel_d;
			pos_q    <= pos_d;
			xor_q    <= xor_d;
		end
	end

	// frame body bytes, no reset
	always_ff @(posedge clk) begin
		if (accept && !item.kind && phase_q == PH_BODY) begin
			for (int i = 2; i <= 7; i++) begin
				if (pos_q == 4'(i)) frame_q[i] <= b;
			end
		end
	end

endmodule

### hw/rtl/cfpt_evq.sv
module cfpt_evq import cfpt_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  ev_t  wdata,
	output logic full,
	input  logic pop,
	output ev_t  rdata,
	output logic valid
);

	localparam int PW = $clog2(EVQ_DEPTH);
	localparam int CW = $clog2(EVQ_DEPTH + 1);

	ev_t           mem_q [EVQ_DEPTH];
	logic [PW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          do_push, do_pop;

	assign full    = (count_q == CW'(EVQ_DEPTH));
	assign valid   = (count_q != '0);
	assign do_push = push && !full;
	assign do_pop  = pop && valid;
	assign rdata   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) mem_q[wr_ptr_q] <= wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) wr_ptr_q <= wr_ptr_q + PW'(1);
			if (do_pop)  rd_ptr_q <= rd_ptr_q + PW'(1);
			if (do_push && !do_pop)      count_q <= count_q + CW'(1);
			else if (do_pop && !do_push) count_q <= count_q - CW'(1);
		end
	end

endmodule

### hw/rtl/cfpt_back.sv
module cfpt_back import cfpt_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        ev_valid,
	input  ev_t         ev,
	output logic        ev_pop,
	input  logic [15:0] timeout_ticks,
	output out_word_t   result,
	output logic        empty,
	input  logic        pop
);

	localparam int PW = $clog2(RESQ_DEPTH);
	localparam int CW = $clog2(RESQ_DEPTH + 1);

	logic [16:0]   elapsed_q, elapsed_d, elapsed_inc;
	logic          online_q, online_d;
	out_word_t     res_d;
	out_word_t     res_q [RESQ_DEPTH];
	logic [PW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          res_full, do_pop;

	assign res_full = (count_q == CW'(RESQ_DEPTH));
	assign empty    = (count_q == '0);
	assign ev_pop   = ev_valid && !res_full;
	assign do_pop   = pop && !empty;
	assign result   = res_q[rd_ptr_q];

	assign elapsed_inc = (elapsed_q < ELAPSED_MAX) ? elapsed_q + 17'd1 : elapsed_q;

	always_comb begin
		elapsed_d           = elapsed_q;
		online_d            = online_q;
		res_d.command_valid = 1'b0;
		res_d.vel_x         = '0;
		res_d.vel_y         = '0;
		res_d.rotation      = '0;
		res_d.action_valid  = 1'b0;
		res_d.action_code   = '0;
		res_d.stop_pulse    = 1'b0;
		case (ev.kind)
			EV_TICK: begin
				elapsed_d = elapsed_inc;
				if (online_q && elapsed_inc > {1'b0, timeout_ticks}) begin
					online_d         = 1'b0;
					res_d.stop_pulse = 1'b1;
				end
			end
			EV_VEL: begin
				elapsed_d           = '0;
				online_d            = 1'b1;
				res_d.command_valid = 1'b1;
				res_d.vel_x         = ev.vel_x;
				res_d.vel_y         = ev.vel_y;
				res_d.rotation      = ev.rotation;
			end
			EV_ACT: begin
				res_d.action_valid = 1'b1;
				res_d.action_code  = ev.action_code;
			end
			default: ;
		endcase
		res_d.link_up = online_d;
	end

	always_ff @(posedge clk) begin
		if (ev_pop) res_q[wr_ptr_q] <= res_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			elapsed_q <= '0;
			online_q  <= 1'b0;
			wr_ptr_q  <= '0;
			rd_ptr_q  <= '0;
			count_q   <= '0;
		end else begin
			if (ev_pop) begin
				elapsed_q <= elapsed_d;
				online_q  <= online_d;
				wr_ptr_q  <= wr_ptr_q + PW'(1);
			end
			if (do_pop) rd_ptr_q <= rd_ptr_q + PW'(1);
			if (ev_pop && !do_pop)      count_q <= count_q + CW'(1);
			else if (do_pop && !ev_pop) count_q <= count_q - CW'(1);
		end
	end

endmodule

### hw/rtl/command_frame_parser_with_timeout.sv
// Command frame parser with link timeout.
// Input queue side: cmd_item carries either a received serial byte (kind 0)
// or a millisecond tick (kind 1); a word is taken when push is high and full
// is low. Every input word yields exactly one result word on cmd_result,
// held while empty is low and taken when pop is high.
// Velocity frames (A5 5A, six data bytes, XOR check) give vel_x, vel_y and
// rotation and bring the link up; action frames (A5 5B, code) give the code
// when it is within action_limit. Ticks age the link; past timeout_ticks the
// link drops with a single stop_pulse.
// Path: each taken input word is classified by the parser front, registered
// in the event queue, then built into a result word registered in the output
// queue; one word per cycle is sustained while full stays low, set by the
// one-byte-a-cycle parser front and the single-step link update at the back.
// Reset: parser waits for the first header, link offline, elapsed count
// zero, action_limit 255, timeout_ticks 500, both queues empty.
// Stall: when pop is held low, up to two results wait in the output queue
// and four words in the event queue; then full rises until pop resumes.
// Registers over APB: action_limit at 0x0, timeout_ticks at 0x4.
`include "command_frame_parser_with_timeout_defines.svh"

module command_frame_parser_with_timeout import cfpt_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  in_word_t    cmd_item,
	output logic        empty,
	input  logic        pop,
	output out_word_t   cmd_result,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	logic [7:0]  action_limit_q;
	logic [15:0] timeout_ticks_q;
	logic        cfg_wr;
	logic        accept;
	ev_t         ev_new, ev_head;
	logic        ev_valid, ev_pop;

	// APB: no wait states; paddr[2] selects the register
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			action_limit_q  <= ACTION_LIMIT_RST;
			timeout_ticks_q <= TIMEOUT_TICKS_RST;
		end else if (cfg_wr) begin
			if (paddr[2] == REG_ACTION_LIMIT) action_limit_q  <= pwdata[7:0];
			else                              timeout_ticks_q <= pwdata[15:0];
		end
	end

	always_comb begin
		if (paddr[2] == REG_TIMEOUT_TICKS) prdata = {16'd0, timeout_ticks_q};
		else                               prdata = {24'd0, action_limit_q};
	end

	// front: classify each word into an event
	assign accept = push && !full;

	cfpt_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.accept       (accept),
		.item         (cmd_item),
		.action_limit (action_limit_q),
		.ev           (ev_new)
	);

	// decouple parser from link state and output stalls
	cfpt_evq u_evq (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (ev_new),
		.full   (full),
		.pop    (ev_pop),
		.rdata  (ev_head),
		.valid  (ev_valid)
	);

	// back: advance the link timer, build and hold result words
	cfpt_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.ev_valid      (ev_valid),
		.ev            (ev_head),
		.ev_pop        (ev_pop),
		.timeout_ticks (timeout_ticks_q),
		.result        (cmd_result),
		.empty         (empty),
		.pop           (pop)
	);

	// a stop pulse always reports the link down
	`CFPT_ASSERT_IMP(a_stop_offline, !empty && cmd_result.stop_pulse, !cmd_result.link_up)
	// a checked velocity frame always reports the link up
	`CFPT_ASSERT_IMP(a_cmd_online, !empty && cmd_result.command_valid, cmd_result.link_up)
	// no result word appears without an event behind it
	`CFPT_ASSERT_NEXT(a_no_phantom, empty && !ev_valid, empty)

endmodule
